### src/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Used by the table engine and the top level; no dependencies.
package ffha_pkg;

	localparam int MAX_BLOCKS   = 1024;
	localparam int HEADER_BYTES = 8;
	localparam int GAP_BYTES    = 4;

	localparam int IDX_W   = $clog2(MAX_BLOCKS);
	localparam int CNT_W   = IDX_W + 1;
	localparam int SIZE_W  = 22;
	localparam int ENTRY_W = SIZE_W + 1;
	localparam int WORD_W  = 32;
	localparam int END_W   = WORD_W + 2;

	localparam logic [WORD_W-1:0] HEADER_W   = WORD_W'(HEADER_BYTES);
	localparam logic [WORD_W-1:0] SPAN_EXTRA = WORD_W'(HEADER_BYTES + GAP_BYTES);
	localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(MAX_BLOCKS);

	localparam logic [WORD_W-1:0] HEAP_BASE_RESET  = 32'h0010_0000;
	localparam logic [WORD_W-1:0] HEAP_LIMIT_RESET = 32'h003E_0000;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK_NEW       = 3'd0,
		ST_OK_REUSED    = 3'd1,
		ST_ZERO_SIZE    = 3'd2,
		ST_NO_MEMORY    = 3'd3,
		ST_FREE_IGNORED = 3'd4
	} status_t;

	typedef struct packed {
		logic [WORD_W-1:0] heap_base;
		logic [WORD_W-1:0] heap_limit;
	} cfg_t;

	typedef struct packed {
		logic              req_type;
		logic [SIZE_W-1:0] request_size;
		logic [WORD_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] data_address;
		status_t           status;
		logic [WORD_W-1:0] used_total;
	} result_t;

endpackage

### src/first_fit_heap_allocator.sv
// First-fit heap allocator: config registers, stream handshake and output register.
// A request walks the descriptor table and may append a block before its result is ready.
// Throughput: one request at a time; the next is taken the cycle after its result
// moves to the output register. The single table read port, one entry a cycle, sets this.
// Reset: control and registers clear asynchronously; the descriptor table is not cleared.
module first_fit_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // request_size[21:0], free_address[53:22], zero pad
	input  logic        s_tuser,  // req_type
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // data_address[31:0], status[34:32], used_total[66:35], pad
);
	import ffha_pkg::*;

	localparam logic REG_HEAP_BASE  = 1'b0;
	localparam logic REG_HEAP_LIMIT = 1'b1;

	logic        reg_sel;
	logic        cfg_write;
	cfg_t        cfg_q;
	req_t        req;
	logic        start;
	logic        eng_idle;
	result_t     res;
	logic        res_take;
	logic        m_tvalid_q;
	result_t     out_q;

	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heap_base  <= HEAP_BASE_RESET;
			cfg_q.heap_limit <= HEAP_LIMIT_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_HEAP_BASE:  cfg_q.heap_base  <= pwdata;
				REG_HEAP_LIMIT: cfg_q.heap_limit <= pwdata;
				default:        cfg_q.heap_base  <= cfg_q.heap_base;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_HEAP_BASE:  prdata = cfg_q.heap_base;
			REG_HEAP_LIMIT: prdata = cfg_q.heap_limit;
			default:        prdata = '0;
		endcase
	end

	assign req.req_type     = s_tuser;
	assign req.request_size = s_tdata[21:0];
	assign req.free_address = s_tdata[53:22];

	assign s_tready = eng_idle;
	assign start    = s_tvalid && s_tready;

	ffha_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.start    (start),
		.req      (req),
		.idle     (eng_idle),
		.res      (res),
		.res_take (res_take)
	);

	// load the output register whenever it is empty or being drained
	assign res_take = res.valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			out_q      <= '0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
			out_q      <= res;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_q.used_total, out_q.status, out_q.data_address};

	// one request in flight: the engine is busy right after taking a beat
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("engine accepted a second request while busy");

	// refused and ignored requests never carry an address
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_q.status == ST_ZERO_SIZE || out_q.status == ST_NO_MEMORY ||
		out_q.status == ST_FREE_IGNORED) |-> out_q.data_address == '0)
		else $error("address returned with a refusal status");

	// a finished result waits unchanged until the output register takes it
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res_take |=> res.valid && $stable(res))
		else $error("pending result lost or changed");

	// the engine is never idle and holding a result at the same time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !res.valid)
		else $error("engine idle with a pending result");

endmodule

### src/ffha_table_ram.sv
// Block descriptor table: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
module ffha_table_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 23
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### src/ffha_engine.sv
// Request engine: walks the descriptor table first-fit, one entry per cycle, and
// writes back used marks or appended blocks. Depends on ffha_pkg and ffha_table_ram.
module ffha_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  ffha_pkg::cfg_t   cfg,
	input  logic             start,
	input  ffha_pkg::req_t   req,
	output logic             idle,
	output ffha_pkg::result_t res,
	input  logic             res_take
);
	import ffha_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_APPEND,
		S_DONE
	} state_t;

	state_t              state_q;
	logic                is_free_q;
	logic [SIZE_W-1:0]   size_q;
	logic [WORD_W-1:0]   faddr_q;
	logic [CNT_W-1:0]    idx_q;
	logic [WORD_W-1:0]   addr_q;
	logic [CNT_W-1:0]    count_q;
	logic [WORD_W-1:0]   top_q;
	logic [WORD_W-1:0]   used_q;
	result_t             res_q;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;

	logic                ent_used;
	logic [SIZE_W-1:0]   ent_size;
	logic [WORD_W-1:0]   ent_span;
	logic [WORD_W-1:0]   req_span;
	logic [CNT_W-1:0]    idx_next;
	logic                alloc_hit;
	logic                free_hit;
	logic                last_entry;
	logic [END_W-1:0]    end_sum;
	logic                append_ok;

	ffha_table_ram #(
		.ADDR_W (IDX_W),
		.DATA_W (ENTRY_W)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ent_used   = ram_rdata[ENTRY_W-1];
	assign ent_size   = ram_rdata[SIZE_W-1:0];
	assign ent_span   = WORD_W'(ent_size) + SPAN_EXTRA;
	assign req_span   = WORD_W'(size_q) + SPAN_EXTRA;
	assign idx_next   = idx_q + CNT_W'(1);
	assign alloc_hit  = !is_free_q && !ent_used && (ent_size >= size_q);
	assign free_hit   = is_free_q && (addr_q == faddr_q);
	assign last_entry = (idx_next == count_q);

	// end of the would-be block, computed without wrap
	assign end_sum   = END_W'(cfg.heap_base) + END_W'(top_q) + END_W'(size_q)
	                 + END_W'(SPAN_EXTRA);
	assign append_ok = (count_q != COUNT_FULL) && (end_sum < END_W'(cfg.heap_limit));

	// read one entry ahead: while entry idx_q is evaluated, idx_q+1 is fetched
	always_comb begin
		case (state_q)
			S_WALK:  ram_raddr = idx_next[IDX_W-1:0];
			default: ram_raddr = '0;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IDX_W-1:0];
		ram_wdata = {1'b0, ent_size};
		case (state_q)
			S_WALK: begin
				if (alloc_hit) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, ent_size};
				end else if (free_hit && ent_used) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b0, ent_size};
				end
			end
			S_APPEND: begin
				ram_we    = append_ok;
				ram_waddr = count_q[IDX_W-1:0];
				ram_wdata = {1'b1, size_q};
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			is_free_q <= 1'b0;
			size_q    <= '0;
			faddr_q   <= '0;
			idx_q     <= '0;
			addr_q    <= '0;
			count_q   <= '0;
			top_q     <= '0;
			used_q    <= '0;
			res_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						is_free_q          <= (req.req_type == REQ_FREE);
						size_q             <= req.request_size;
						faddr_q            <= req.free_address;
						idx_q              <= '0;
						addr_q             <= cfg.heap_base + HEADER_W;
						res_q.data_address <= '0;
						res_q.used_total   <= used_q;
						if (req.req_type == REQ_ALLOC) begin
							if (req.request_size == '0) begin
								res_q.status <= ST_ZERO_SIZE;
								state_q      <= S_DONE;
							end else if (count_q == '0) begin
								state_q <= S_APPEND;
							end else begin
								state_q <= S_WALK;
							end
						end else if (req.free_address == '0 || count_q == '0) begin
							res_q.status <= ST_FREE_IGNORED;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (alloc_hit) begin
						used_q             <= used_q + ent_span;
						res_q.data_address <= addr_q;
						res_q.status       <= ST_OK_REUSED;
						res_q.used_total   <= used_q + ent_span;
						state_q            <= S_DONE;
					end else if (free_hit) begin
						if (ent_used) begin
							used_q           <= used_q - ent_span;
							res_q.status     <= ST_OK_NEW;
							res_q.used_total <= used_q - ent_span;
						end else begin
							res_q.status <= ST_FREE_IGNORED;
						end
						state_q <= S_DONE;
					end else if (last_entry) begin
						if (is_free_q) begin
							res_q.status <= ST_FREE_IGNORED;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_APPEND;
						end
					end else begin
						idx_q  <= idx_next;
						addr_q <= addr_q + ent_span;
					end
				end
				S_APPEND: begin
					if (append_ok) begin
						count_q            <= count_q + CNT_W'(1);
						top_q              <= top_q + req_span;
						used_q             <= used_q + req_span;
						res_q.data_address <= cfg.heap_base + top_q + HEADER_W;
						res_q.status       <= ST_OK_NEW;
						res_q.used_total   <= used_q + req_span;
					end else begin
						res_q.status <= ST_NO_MEMORY;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold the result until the output register takes it
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);

	always_comb begin
		res       = res_q;
		res.valid = (state_q == S_DONE);
	end

endmodule

### tb/heap_tracker_pkg.sv
// Scoreboard for the first-fit heap allocator bench: keeps its own block table,
// predicts every reply and checks the result stream against it. Depends on ffha_pkg.
`timescale 1ns / 100ps
package heap_tracker_pkg;
	import ffha_pkg::*;

	localparam logic [2:0] REG_HEAP_BASE  = 3'd0;
	localparam logic [2:0] REG_HEAP_LIMIT = 3'd4;

	typedef struct packed {
		logic [WORD_W-1:0] data_address;
		status_t           status;
		logic [WORD_W-1:0] used_total;
	} heap_reply_t;

	class heap_tracker;
		logic [WORD_W-1:0]  base_addr;
		logic [WORD_W-1:0]  limit_addr;
		logic [ENTRY_W-1:0] blocks [MAX_BLOCKS];
		int unsigned        count;
		logic [WORD_W-1:0]  top;
		logic [WORD_W-1:0]  in_use;
		heap_reply_t        awaited [$];
		int unsigned        errors;

		function new();
			base_addr  = HEAP_BASE_RESET;
			limit_addr = HEAP_LIMIT_RESET;
			count      = 0;
			top        = '0;
			in_use     = '0;
			errors     = 0;
			foreach (blocks[i]) blocks[i] = '0;
		endfunction

		function logic [WORD_W-1:0] span(logic [SIZE_W-1:0] sz);
			return WORD_W'(sz) + SPAN_EXTRA;
		endfunction

		// data address of block idx under the current base
		function logic [WORD_W-1:0] block_address(int unsigned idx);
			logic [WORD_W-1:0] off;
			off = '0;
			for (int unsigned i = 0; i < idx; i++) off += span(blocks[i][SIZE_W-1:0]);
			return base_addr + off + HEADER_W;
		endfunction

		function void set_config(logic [2:0] a, logic [WORD_W-1:0] v);
			if (a == REG_HEAP_BASE) base_addr = v;
			else if (a == REG_HEAP_LIMIT) limit_addr = v;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void note_request(req_t rq);
			heap_reply_t       r;
			logic [WORD_W-1:0] off;
			logic [SIZE_W-1:0] bsize;
			logic [END_W-1:0]  top_end;
			bit                found;
			r.data_address = '0;
			r.status       = ST_FREE_IGNORED;
			off            = '0;
			found          = 1'b0;
			if (rq.req_type == REQ_ALLOC) begin
				if (rq.request_size == '0) begin
					r.status = ST_ZERO_SIZE;
				end else begin
					// first fit; a reused block keeps its stored size
					for (int unsigned i = 0; i < count && !found; i++) begin
						bsize = blocks[i][SIZE_W-1:0];
						if (!blocks[i][SIZE_W] && bsize >= rq.request_size) begin
							blocks[i][SIZE_W] = 1'b1;
							in_use += span(bsize);
							r.data_address = base_addr + off + HEADER_W;
							r.status = ST_OK_REUSED;
							found = 1'b1;
						end else begin
							off += span(bsize);
						end
					end
					if (!found) begin
						// end of the new block, no wrap
						top_end = END_W'(base_addr) + END_W'(top) + END_W'(rq.request_size)
							+ END_W'(SPAN_EXTRA);
						if (count >= MAX_BLOCKS || top_end >= END_W'(limit_addr)) begin
							r.status = ST_NO_MEMORY;
						end else begin
							blocks[count] = {1'b1, rq.request_size};
							count++;
							r.data_address = base_addr + top + HEADER_W;
							top += span(rq.request_size);
							in_use += span(rq.request_size);
							r.status = ST_OK_NEW;
						end
					end
				end
			end else if (rq.free_address != '0) begin
				// first matching address wins, even if that block is already free
				for (int unsigned i = 0; i < count && !found; i++) begin
					bsize = blocks[i][SIZE_W-1:0];
					if (base_addr + off + HEADER_W == rq.free_address) begin
						if (blocks[i][SIZE_W]) begin
							blocks[i][SIZE_W] = 1'b0;
							in_use -= span(bsize);
							r.status = ST_OK_NEW;
						end
						found = 1'b1;
					end else begin
						off += span(bsize);
					end
				end
			end
			r.used_total = in_use;
			awaited.push_back(r);
		endfunction

		function void check_result(logic [WORD_W-1:0] addr, status_t st, logic [WORD_W-1:0] used);
			heap_reply_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected beat: addr %h status %0d used %h", $time, addr, st, used);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (addr !== want.data_address) begin
				$display("%0t: data_address expected %h actual %h", $time, want.data_address, addr);
				errors++;
			end
			if (st !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, st);
				errors++;
			end
			if (used !== want.used_total) begin
				$display("%0t: used_total expected %h actual %h", $time, want.used_total, used);
				errors++;
			end
		endfunction
	endclass

endpackage

### tb/tb.sv
// Top of the first-fit heap allocator bench: clock, reset, APB writes, request and
// result streams. Depends on ffha_pkg, heap_tracker_pkg and first_fit_heap_allocator.
`timescale 1ns / 100ps
module tb;
	import ffha_pkg::*;
	import heap_tracker_pkg::*;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;  // request_size[21:0], free_address[53:22], zero pad
	logic        s_tuser  = 1'b0; // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;        // data_address[31:0], status[34:32], used_total[66:35], pad

	int unsigned send_idle_pct = 25;
	int unsigned recv_idle_pct = 58;
	heap_tracker tracker = new();

	first_fit_heap_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata[31:0], status_t'(m_tdata[34:32]), m_tdata[66:35]);
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_request(input logic kind, input logic [SIZE_W-1:0] sz,
		input logic [WORD_W-1:0] addr);
		req_t rq;
		rq.req_type     = kind;
		rq.request_size = sz;
		rq.free_address = addr;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, addr, sz};
		do @(posedge clk); while (!s_tready);
		tracker.note_request(rq);
	endtask

	task automatic write_reg(input logic [2:0] a, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_config(a, v);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly allocations and frees of live blocks; the rest is noise
	task automatic random_request();
		int unsigned       roll;
		int unsigned       pick;
		logic [SIZE_W-1:0] sz;
		logic [WORD_W-1:0] addr;
		roll = $urandom_range(99);
		pick = $urandom_range(99);
		sz   = SIZE_W'($urandom);
		addr = $urandom;
		if (roll < 55) begin
			if (pick < 65)
				sz = SIZE_W'($urandom_range(256, 1));
			else if (pick < 82 && tracker.count != 0)
				sz = tracker.blocks[$urandom_range(tracker.count - 1)][SIZE_W-1:0];
			else if (pick < 90)
				sz = SIZE_W'($urandom_range(65535, 257));
			else if (pick < 94)
				sz = '0;
			send_request(REQ_ALLOC, sz, addr);
		end else if (roll < 95) begin
			if (pick < 82 && tracker.count != 0)
				addr = tracker.block_address($urandom_range(tracker.count - 1));
			else if (pick < 90)
				addr = '0;
			send_request(REQ_FREE, sz, addr);
		end else begin
			send_request(1'($urandom_range(1)), sz, addr);
		end
	endtask

	initial begin
		logic [SIZE_W-1:0] room;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default window
		send_request(REQ_ALLOC, '0, 32'h0);
		send_request(REQ_FREE, '1, 32'h0);
		send_request(REQ_ALLOC, SIZE_W'(1), '1);
		send_request(REQ_ALLOC, '1, 32'h0);
		send_request(REQ_ALLOC, SIZE_W'(100), 32'h0);
		send_request(REQ_ALLOC, SIZE_W'(37), 32'h0);
		send_request(REQ_FREE, '0, tracker.block_address(1));
		send_request(REQ_FREE, '0, tracker.block_address(1));
		send_request(REQ_FREE, '0, tracker.block_address(1) + 32'd4);
		send_request(REQ_ALLOC, SIZE_W'(100), 32'h0);
		send_request(REQ_FREE, '0, tracker.block_address(1));
		send_request(REQ_ALLOC, SIZE_W'(60), 32'h0);
		send_request(REQ_FREE, '0, tracker.block_address(0));
		send_request(REQ_FREE, '0, tracker.block_address(2));
		send_request(REQ_ALLOC, SIZE_W'(2), 32'h0);
		send_request(REQ_ALLOC, SIZE_W'(1), 32'h0);
		send_request(REQ_FREE, '0, '1);
		// block ending exactly at the limit is refused, one byte less fits
		room = SIZE_W'(tracker.limit_addr - tracker.base_addr - tracker.top - SPAN_EXTRA);
		send_request(REQ_ALLOC, room, 32'h0);
		send_request(REQ_ALLOC, room - SIZE_W'(1), 32'h0);
		send_request(REQ_ALLOC, SIZE_W'(1), 32'h0);
		wait_idle();

		// wide open heap from address zero
		write_reg(REG_HEAP_BASE, 32'h0);
		write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
		repeat (200) random_request();
		wait_idle();

		// wrapping addresses, no room to append
		send_idle_pct = 58;
		recv_idle_pct = 25;
		write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
		write_reg(REG_HEAP_LIMIT, 32'h0);
		repeat (170) random_request();
		wait_idle();

		// tight limit so appends run out now and then
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_HEAP_BASE, 32'h0000_1000);
		write_reg(REG_HEAP_LIMIT, 32'h0000_1000 + tracker.top + 32'd200000);
		repeat (160) random_request();
		wait_idle();

		// open the limit again and request a few more small blocks
		write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
		repeat (3) send_request(REQ_ALLOC, SIZE_W'($urandom_range(64, 1)), $urandom);
		repeat (20) random_request();
		wait_idle();
		repeat (MAX_BLOCKS + 4) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
